// ===== hdl/bpps_pkg.sv =====
// ---------------------------------------------------------------------------
// bpps_pkg
// Shared types, register codes and constants of the point light shader.
// ---------------------------------------------------------------------------
package bpps_pkg;

    localparam int MAX_LIGHTS_DEF = 4;

    localparam logic [2:0] REG_EYE_X  = 3'd0;
    localparam logic [2:0] REG_EYE_Y  = 3'd1;
    localparam logic [2:0] REG_EYE_Z  = 3'd2;
    localparam logic [2:0] REG_SHINE  = 3'd3;
    localparam logic [2:0] REG_KS     = 3'd4;
    localparam logic [2:0] REG_AMB    = 3'd5;
    localparam logic [2:0] REG_LIGHTS = 3'd6;

    localparam logic [15:0] SHINE_RST = 16'd38400;
    localparam logic [15:0] KS_RST    = 16'd52015;
    localparam logic [15:0] AMB_RST   = 16'd3277;

    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [40:0] ISCALE_CAP = 41'h100_0000_0000;

    typedef struct packed {
        logic [31:0] eye_x;
        logic [31:0] eye_y;
        logic [31:0] eye_z;
        logic [15:0] shine;
        logic [15:0] ks;
        logic [15:0] amb;
        logic [2:0]  lights;
    } t_cfg;

    typedef struct packed {
        logic             is_load;
        logic [1:0]       slot;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vec;
    } t_word;

endpackage

// ===== hdl/bpps_div.sv =====
// ---------------------------------------------------------------------------
// bpps_div
// Unsigned 64 by 64 bit restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bpps_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_quot
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_den;
    logic [64:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_quo[63]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? 64'(w_trial - {1'b0, r_den}) : w_trial[63:0];
                r_quo <= {r_quo[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== hdl/bpps_sqrt.sv =====
// ---------------------------------------------------------------------------
// bpps_sqrt
// Floor square root of a 64 bit value, one root bit per cycle.
// ---------------------------------------------------------------------------
module bpps_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_arg,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_arg;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] w_rem;
    logic [34:0] w_trial;
    logic        w_ge;

    assign w_rem   = {r_rem[32:0], r_arg[63:62]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = w_rem >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_arg  <= i_arg;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_arg  <= {r_arg[61:0], 2'b00};
                r_rem  <= w_ge ? 35'(w_rem - w_trial) : w_rem;
                r_root <= {r_root[30:0], w_ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== hdl/bpps_front.sv =====
// ---------------------------------------------------------------------------
// bpps_front
// Input side: takes words, drops loads to absent slots, two-entry queue.
// ---------------------------------------------------------------------------
module bpps_front #(
    parameter int MAX_LIGHTS = bpps_pkg::MAX_LIGHTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_cmd,
    input  logic [1:0]          i_light_slot,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic signed [31:0]  i_vec_x,
    input  logic signed [31:0]  i_vec_y,
    input  logic signed [31:0]  i_vec_z,
    output logic                o_q_valid,
    output bpps_pkg::t_word     o_q_word,
    input  logic                i_q_pop
);
    import bpps_pkg::*;

    t_word      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_keep;
    logic       w_push;
    t_word      w_word;

    assign w_keep = !i_cmd || ({3'b000, i_light_slot} < 5'(MAX_LIGHTS));
    assign w_push = i_valid && !o_stall && w_keep;

    always_comb begin
        w_word.is_load = i_cmd;
        w_word.slot    = i_light_slot;
        w_word.pos     = {i_pos_z, i_pos_y, i_pos_x};
        w_word.vec     = {i_vec_z, i_vec_y, i_vec_x};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= w_word;
                r_wp        <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

    assign o_stall   = r_cnt == 2'd2;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q_word  = r_mem[r_rp];
endmodule

// ===== hdl/bpps_back.sv =====
// ---------------------------------------------------------------------------
// bpps_back
// Shading sequencer: light table, per-light loop over shared divider and
// square root, output register.
// ---------------------------------------------------------------------------
module bpps_back #(
    parameter int MAX_LIGHTS = bpps_pkg::MAX_LIGHTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bpps_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  bpps_pkg::t_word i_q_word,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_red,
    output logic [15:0]     o_green,
    output logic [15:0]     o_blue
);
    import bpps_pkg::*;

    localparam int SW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int KW = $clog2(MAX_LIGHTS + 1);
    localparam int CW = (KW > 3) ? KW : 3;

    typedef enum logic [4:0] {
        S_IDLE, U_INIT, U_SHIFT, U_SQ, U_SQRT_GO, U_SQRT_W, U_DIV_GO, U_DIV_W,
        U_RET, S_LSTART, S_DSQ, S_DOTL, S_DOTL_E, S_DOTH, S_DOTH_E, S_PINIT,
        S_PINT, S_PINT2, S_PF_GO, S_PF_W, S_PF_MUL, S_SPEC, S_IC, S_IC_W,
        S_ACC1, S_ACC2, S_NEXT, S_FIN
    } t_state;

    typedef enum logic [1:0] {RET_EYE, RET_LIGHT, RET_HALF} t_ret;

    t_state             r_state;
    t_ret               r_ret;
    logic signed [31:0] r_p  [3];
    logic signed [31:0] r_n  [3];
    logic signed [31:0] r_ue [3];
    logic signed [31:0] r_ul [3];
    logic signed [31:0] r_uh [3];
    logic signed [31:0] r_uo [3];
    logic signed [33:0] r_v  [3];
    logic [33:0]        r_mag [3];
    logic               r_sgn [3];
    logic [33:0]        r_mx;
    logic [63:0]        r_sum;
    logic [31:0]        r_len;
    logic [1:0]         r_i;
    logic [31:0]        r_lpos [MAX_LIGHTS][3];
    logic [31:0]        r_lint [MAX_LIGHTS][3];
    logic [KW-1:0]      r_k;
    logic [CW-1:0]      r_cnt;
    logic [65:0]        r_dsq;
    logic signed [65:0] r_dot;
    logic [16:0]        r_ndl;
    logic [16:0]        r_ndh;
    logic [30:0]        r_base;
    logic [30:0]        r_pacc;
    logic [30:0]        r_root;
    logic [2:0]         r_j;
    logic [16:0]        r_spec;
    logic signed [41:0] r_ic;
    logic signed [43:0] r_t1;
    logic signed [47:0] r_acc [3];
    logic               r_div_go;
    logic [63:0]        r_div_num;
    logic [63:0]        r_div_den;
    logic               r_sq_go;
    logic [63:0]        r_sq_arg;
    logic               r_ov;
    logic [15:0]        r_red;
    logic [15:0]        r_green;
    logic [15:0]        r_blue;

    logic               w_div_busy, w_div_done;
    logic [63:0]        w_quot;
    logic               w_sq_busy, w_sq_done;
    logic [31:0]        w_root;

    logic [33:0]        w_mag [3];
    logic [33:0]        w_mx;
    logic [29:0]        w_m30;
    logic [59:0]        w_sq;
    logic [31:0]        w_m32;
    logic [63:0]        w_d2;
    logic signed [31:0] w_uv;
    logic signed [63:0] w_dotp;
    logic [30:0]        w_pa, w_pb;
    logic [61:0]        w_pm;
    logic [32:0]        w_ks;
    logic signed [17:0] w_fac;
    logic signed [59:0] w_icp;
    logic [63:0]        w_dsq;
    logic [SW-1:0]      w_ki;
    logic [SW+1:0]      w_sx;
    logic [SW-1:0]      w_slot;
    logic [CW-1:0]      w_lu;
    logic [31:0]        w_raw;
    logic [31:0]        w_im;
    logic [40:0]        w_qc;
    logic               w_out_free;

    function automatic logic signed [43:0] f_tdiv16(input logic signed [59:0] x);
        logic signed [59:0] a;
        a = x + (x[59] ? 60'sd65535 : 60'sd0);
        return a[59:16];
    endfunction

    function automatic logic [16:0] f_clamp(input logic signed [65:0] s);
        logic [35:0] sh;
        sh = s[65:30];
        if (s[65]) begin
            return 17'd0;
        end else if (sh > 36'd65536) begin
            return 17'd65536;
        end else begin
            return sh[16:0];
        end
    endfunction

    function automatic logic [15:0] f_sat16(input logic signed [47:0] c);
        if (c[47]) begin
            return 16'd0;
        end else if (c > 48'sd65535) begin
            return 16'hFFFF;
        end else begin
            return c[15:0];
        end
    endfunction

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_v[i][33] ? 34'(-r_v[i]) : 34'(r_v[i]);
        end
        w_mx = w_mag[0];
        if (w_mag[1] > w_mx) w_mx = w_mag[1];
        if (w_mag[2] > w_mx) w_mx = w_mag[2];
    end

    assign w_m30  = r_mag[r_i][29:0];
    assign w_sq   = w_m30 * w_m30;
    assign w_m32  = w_mag[r_i][31:0];
    assign w_d2   = w_m32 * w_m32;
    assign w_uv   = (r_state == S_DOTL) ? r_ul[r_i] : r_uh[r_i];
    assign w_dotp = r_n[r_i] * w_uv;
    assign w_pa   = (r_state == S_PINT2) ? r_base : r_pacc;
    assign w_pb   = (r_state == S_PF_MUL) ? r_root : r_base;
    assign w_pm   = w_pa * w_pb;
    assign w_ks   = i_cfg.ks * r_pacc[30:14];
    assign w_fac  = {1'b0, (r_state == S_ACC1) ? r_ndl : r_spec};
    assign w_icp  = r_ic * w_fac;
    assign w_dsq  = (r_dsq[65:64] != 2'b00) ? 64'hFFFF_FFFF_FFFF_FFFF : r_dsq[63:0];
    assign w_ki   = r_k[SW-1:0];
    assign w_sx   = (SW + 2)'(i_q_word.slot);
    assign w_slot = w_sx[SW-1:0];
    assign w_lu   = CW'(i_cfg.lights);
    assign w_raw  = r_lint[w_ki][r_i];
    assign w_im   = w_raw[31] ? 32'(-w_raw) : w_raw;
    assign w_qc   = (w_quot > 64'(ISCALE_CAP)) ? ISCALE_CAP : w_quot[40:0];
    assign w_out_free = !r_ov || !i_stall;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            r_k      <= '0;
            for (int l = 0; l < MAX_LIGHTS; l++) begin
                for (int i = 0; i < 3; i++) begin
                    r_lpos[l][i] <= '0;
                    r_lint[l][i] <= '0;
                end
            end
        end else begin
            r_div_go <= 1'b0;
            r_sq_go  <= 1'b0;
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        if (i_q_word.is_load) begin
                            for (int i = 0; i < 3; i++) begin
                                r_lpos[w_slot][i] <= i_q_word.pos[i];
                                r_lint[w_slot][i] <= i_q_word.vec[i];
                            end
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_p[i]   <= i_q_word.pos[i];
                                r_n[i]   <= i_q_word.vec[i];
                                r_acc[i] <= '0;
                            end
                            r_v[0] <= {{2{i_cfg.eye_x[31]}}, i_cfg.eye_x}
                                    - {{2{i_q_word.pos[0][31]}}, i_q_word.pos[0]};
                            r_v[1] <= {{2{i_cfg.eye_y[31]}}, i_cfg.eye_y}
                                    - {{2{i_q_word.pos[1][31]}}, i_q_word.pos[1]};
                            r_v[2] <= {{2{i_cfg.eye_z[31]}}, i_cfg.eye_z}
                                    - {{2{i_q_word.pos[2][31]}}, i_q_word.pos[2]};
                            r_cnt   <= (w_lu > CW'(MAX_LIGHTS)) ? CW'(MAX_LIGHTS) : w_lu;
                            r_k     <= '0;
                            r_ret   <= RET_EYE;
                            r_state <= U_INIT;
                        end
                    end
                end
                U_INIT: begin
                    if (w_mx == '0) begin
                        for (int i = 0; i < 3; i++) r_uo[i] <= '0;
                        r_state <= U_RET;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= w_mag[i];
                            r_sgn[i] <= r_v[i][33];
                        end
                        r_mx    <= w_mx;
                        r_state <= U_SHIFT;
                    end
                end
                U_SHIFT: begin
                    if (r_mx[33:30] != 4'd0) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                        r_mx <= r_mx >> 1;
                    end else if (!r_mx[29]) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                        r_mx <= r_mx << 1;
                    end else begin
                        r_sum   <= '0;
                        r_i     <= '0;
                        r_state <= U_SQ;
                    end
                end
                U_SQ: begin
                    r_sum <= r_sum + 64'(w_sq);
                    if (r_i == 2'd2) begin
                        r_state <= U_SQRT_GO;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                U_SQRT_GO: begin
                    r_sq_go  <= 1'b1;
                    r_sq_arg <= r_sum;
                    r_state  <= U_SQRT_W;
                end
                U_SQRT_W: begin
                    if (w_sq_done) begin
                        r_len   <= w_root;
                        r_i     <= '0;
                        r_state <= U_DIV_GO;
                    end
                end
                U_DIV_GO: begin
                    r_div_go  <= 1'b1;
                    r_div_num <= {4'b0000, w_m30, 30'd0};
                    r_div_den <= {32'd0, r_len};
                    r_state   <= U_DIV_W;
                end
                U_DIV_W: begin
                    if (w_div_done) begin
                        r_uo[r_i] <= r_sgn[r_i] ? -$signed(w_quot[31:0])
                                                : $signed(w_quot[31:0]);
                        if (r_i == 2'd2) begin
                            r_state <= U_RET;
                        end else begin
                            r_i     <= r_i + 2'd1;
                            r_state <= U_DIV_GO;
                        end
                    end
                end
                U_RET: begin
                    case (r_ret)
                        RET_EYE: begin
                            r_ue    <= r_uo;
                            r_state <= (r_cnt == '0) ? S_FIN : S_LSTART;
                        end
                        RET_LIGHT: begin
                            r_ul <= r_uo;
                            for (int i = 0; i < 3; i++) begin
                                r_v[i] <= {{2{r_uo[i][31]}}, r_uo[i]}
                                        + {{2{r_ue[i][31]}}, r_ue[i]};
                            end
                            r_ret   <= RET_HALF;
                            r_state <= U_INIT;
                        end
                        default: begin
                            r_uh    <= r_uo;
                            r_dot   <= '0;
                            r_i     <= '0;
                            r_state <= S_DOTL;
                        end
                    endcase
                end
                S_LSTART: begin
                    for (int i = 0; i < 3; i++) begin
                        r_v[i] <= {{2{r_lpos[w_ki][i][31]}}, r_lpos[w_ki][i]}
                                - {{2{r_p[i][31]}}, r_p[i]};
                    end
                    r_dsq   <= '0;
                    r_i     <= '0;
                    r_state <= S_DSQ;
                end
                S_DSQ: begin
                    r_dsq <= r_dsq + 66'(w_d2);
                    if (r_i == 2'd2) begin
                        r_ret   <= RET_LIGHT;
                        r_state <= U_INIT;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                S_DOTL, S_DOTH: begin
                    r_dot <= r_dot + {{2{w_dotp[63]}}, w_dotp};
                    if (r_i == 2'd2) begin
                        r_state <= (r_state == S_DOTL) ? S_DOTL_E : S_DOTH_E;
                    end else begin
                        r_i <= r_i + 2'd1;
                    end
                end
                S_DOTL_E: begin
                    r_ndl   <= f_clamp(r_dot);
                    r_dot   <= '0;
                    r_i     <= '0;
                    r_state <= S_DOTH;
                end
                S_DOTH_E: begin
                    r_ndh   <= f_clamp(r_dot);
                    r_state <= S_PINIT;
                end
                S_PINIT: begin
                    r_base  <= {r_ndh, 14'd0};
                    r_root  <= {r_ndh, 14'd0};
                    r_pacc  <= ONE_Q30;
                    r_j     <= '0;
                    r_state <= S_PINT;
                end
                S_PINT: begin
                    if (i_cfg.shine[8 + r_j]) r_pacc <= w_pm[60:30];
                    r_state <= S_PINT2;
                end
                S_PINT2: begin
                    r_base <= w_pm[60:30];
                    if (r_j == 3'd7) begin
                        r_state <= S_PF_GO;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_PINT;
                    end
                end
                S_PF_GO: begin
                    r_sq_go  <= 1'b1;
                    r_sq_arg <= {3'b000, r_root, 30'd0};
                    r_state  <= S_PF_W;
                end
                S_PF_W: begin
                    if (w_sq_done) begin
                        r_root  <= w_root[30:0];
                        r_state <= S_PF_MUL;
                    end
                end
                S_PF_MUL: begin
                    if (i_cfg.shine[r_j]) r_pacc <= w_pm[60:30];
                    if (r_j == 3'd0) begin
                        r_state <= S_SPEC;
                    end else begin
                        r_j     <= r_j - 3'd1;
                        r_state <= S_PF_GO;
                    end
                end
                S_SPEC: begin
                    r_spec  <= w_ks[32:16];
                    r_i     <= '0;
                    r_state <= S_IC;
                end
                S_IC: begin
                    if (w_im == '0) begin
                        r_ic    <= '0;
                        r_state <= S_ACC1;
                    end else if (w_dsq == '0) begin
                        r_ic    <= w_raw[31] ? -$signed({1'b0, ISCALE_CAP})
                                             : $signed({1'b0, ISCALE_CAP});
                        r_state <= S_ACC1;
                    end else begin
                        r_div_go  <= 1'b1;
                        r_div_num <= {w_im, 32'd0};
                        r_div_den <= w_dsq;
                        r_state   <= S_IC_W;
                    end
                end
                S_IC_W: begin
                    if (w_div_done) begin
                        r_ic    <= w_raw[31] ? -$signed({1'b0, w_qc}) : $signed({1'b0, w_qc});
                        r_state <= S_ACC1;
                    end
                end
                S_ACC1: begin
                    r_t1    <= f_tdiv16(w_icp);
                    r_state <= S_ACC2;
                end
                S_ACC2: begin
                    r_acc[r_i] <= r_acc[r_i] + $signed({32'd0, i_cfg.amb})
                                + 48'(r_t1) + 48'(f_tdiv16(w_icp));
                    if (r_i == 2'd2) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_i     <= r_i + 2'd1;
                        r_state <= S_IC;
                    end
                end
                S_NEXT: begin
                    if (CW'(r_k) + CW'(1) < r_cnt) begin
                        r_k     <= r_k + KW'(1);
                        r_state <= S_LSTART;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_red   <= f_sat16(r_acc[0]);
                        r_green <= f_sat16(r_acc[1]);
                        r_blue  <= f_sat16(r_acc[2]);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    bpps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    bpps_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_sq_go),
        .i_arg   (r_sq_arg),
        .o_busy  (w_sq_busy),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign o_valid = r_ov;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

`ifndef SYNTH
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_div_busy && w_sq_busy))
        else $error("divider and square root busy together");

    a_light_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'(r_k) < CW'(MAX_LIGHTS))
        else $error("light index out of range");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && w_out_free |=> r_ov)
        else $error("finished word not presented");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_IDLE) || (r_state == U_INIT))
        else $error("queue popped outside idle");
`endif
endmodule

// ===== hdl/blinn_phong_point_light_shader.sv =====
// Throughput: one shade word at a time; two words queue at the input.
// Reset: synchronous, active low; registers to defaults, light table to zero,
//   no clearing pass.
// ---------------------------------------------------------------------------
// blinn_phong_point_light_shader
// Point light shader top level: configuration registers, front and back.
// ---------------------------------------------------------------------------
module blinn_phong_point_light_shader #(
    parameter int MAX_LIGHTS = bpps_pkg::MAX_LIGHTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_cmd,
    input  logic [1:0]         i_light_slot,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_red,
    output logic [15:0]        o_green,
    output logic [15:0]        o_blue
);
    import bpps_pkg::*;

    t_cfg  r_cfg;
    logic  w_wr;
    logic  w_q_valid;
    t_word w_q_word;
    logic  w_q_pop;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eye_x  <= '0;
            r_cfg.eye_y  <= '0;
            r_cfg.eye_z  <= '0;
            r_cfg.shine  <= SHINE_RST;
            r_cfg.ks     <= KS_RST;
            r_cfg.amb    <= AMB_RST;
            r_cfg.lights <= '0;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_EYE_X:  r_cfg.eye_x  <= pwdata;
                REG_EYE_Y:  r_cfg.eye_y  <= pwdata;
                REG_EYE_Z:  r_cfg.eye_z  <= pwdata;
                REG_SHINE:  r_cfg.shine  <= pwdata[15:0];
                REG_KS:     r_cfg.ks     <= pwdata[15:0];
                REG_AMB:    r_cfg.amb    <= pwdata[15:0];
                REG_LIGHTS: r_cfg.lights <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_EYE_X:  prdata = r_cfg.eye_x;
            REG_EYE_Y:  prdata = r_cfg.eye_y;
            REG_EYE_Z:  prdata = r_cfg.eye_z;
            REG_SHINE:  prdata = {16'd0, r_cfg.shine};
            REG_KS:     prdata = {16'd0, r_cfg.ks};
            REG_AMB:    prdata = {16'd0, r_cfg.amb};
            REG_LIGHTS: prdata = {29'd0, r_cfg.lights};
            default:    prdata = '0;
        endcase
    end

    bpps_front #(.MAX_LIGHTS(MAX_LIGHTS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_light_slot (i_light_slot),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_vec_x      (i_vec_x),
        .i_vec_y      (i_vec_y),
        .i_vec_z      (i_vec_z),
        .o_q_valid    (w_q_valid),
        .o_q_word     (w_q_word),
        .i_q_pop      (w_q_pop)
    );

    bpps_back #(.MAX_LIGHTS(MAX_LIGHTS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_word  (w_q_word),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );
endmodule
